@@ src/get_pkg.sv @@
// Shared types and constants of the generational entity table.
package get_pkg;

    localparam int unsigned DEF_ENTRY_COUNT     = 64;
    localparam int unsigned DEF_COMPONENT_COUNT = 16;
    localparam int unsigned DEF_FLAG_WIDTH      = 16;
    localparam int unsigned DEF_VERSION_WIDTH   = 16;

    localparam int unsigned CMD_W    = 4;
    localparam int unsigned IDX_W    = 6;
    localparam int unsigned HVER_W   = 16;
    localparam int unsigned CID_W    = 4;
    localparam int unsigned QUERY_W  = 16;
    localparam int unsigned STATUS_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE      = 4'd0,
        CMD_KILL        = 4'd1,
        CMD_REINCARNATE = 4'd2,
        CMD_SET_IMMORT  = 4'd3,
        CMD_ADD_COMP    = 4'd4,
        CMD_REM_COMP    = 4'd5,
        CMD_QUERY       = 4'd6,
        CMD_SET_FLAGS   = 4'd7,
        CMD_CLR_FLAGS   = 4'd8,
        CMD_FIND        = 4'd9,
        CMD_ITERATE     = 4'd10
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_REJECTED = 3'd2,
        ST_FULL     = 3'd3,
        ST_NO_MATCH = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_SCAN = 3'b100
    } t_state;

endpackage

@@ src/generational_entity_table.sv @@
// Top level of the generational entity table: command sequencer around the entry RAM.
//
// A request is taken when start is high and busy is low; its fields are sampled then.
// Every result appears for exactly one cycle with o_strobe high, and o_last marks the
// final result of a request. The receiver cannot stall the block.
// Handle commands (kill, reincarnate, set immortal, add or remove component, query,
// set or clear flags) and unused codes read their entry and give their result from
// S_EXEC, the only state in which they keep busy high. Unused codes are rejected and
// query writes nothing; the rest modify the entry and write it back unless the handle
// is invalid or they are rejected. Create, find and iterate sweep the entry RAM at one
// entry per cycle; create stops at the first free entry, find at the first match.
// Iterate gives one result per matching entry, sent when the next is found or at the end.
// All entries live in one RAM with a registered read. A per-entry written bit, cleared by
// reset, makes an unwritten entry read as all zero, so no clearing pass is needed and
// the block accepts requests in the cycle after reset is released.
module generational_entity_table
    import get_pkg::*;
#(
    parameter int unsigned ENTRY_COUNT     = DEF_ENTRY_COUNT,
    parameter int unsigned COMPONENT_COUNT = DEF_COMPONENT_COUNT,
    parameter int unsigned FLAG_WIDTH      = DEF_FLAG_WIDTH,
    parameter int unsigned VERSION_WIDTH   = DEF_VERSION_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [IDX_W-1:0]    i_entry_index,
    input  logic [HVER_W-1:0]   i_entry_version,
    input  logic [CID_W-1:0]    i_component_id,
    input  logic                i_immortal_value,
    input  logic [QUERY_W-1:0]  i_component_query,
    input  logic [QUERY_W-1:0]  i_flag_bits,
    output logic                o_strobe,
    output logic [STATUS_W-1:0] o_status,
    output logic [IDX_W-1:0]    o_out_index,
    output logic [HVER_W-1:0]   o_out_version,
    output logic                o_handle_valid,
    output logic                o_is_alive,
    output logic                o_is_immortal,
    output logic                o_has_component,
    output logic                o_any_flag,
    output logic                o_last
);

    localparam int unsigned AW = $clog2(ENTRY_COUNT);
    localparam int unsigned VW = VERSION_WIDTH;
    localparam int unsigned CC = COMPONENT_COUNT;
    localparam int unsigned FW = FLAG_WIDTH;
    localparam int unsigned AL = VW;
    localparam int unsigned IL = VW + 1;
    localparam int unsigned CL = VW + 2;
    localparam int unsigned FL = VW + 2 + CC;
    localparam int unsigned EW = FL + FW;

    t_state r_state, n_state;
    logic [CMD_W-1:0]   r_cmd, n_cmd;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [HVER_W-1:0]  r_ver, n_ver;
    logic [CID_W-1:0]   r_cid, n_cid;
    logic               r_imm, n_imm;
    logic [QUERY_W-1:0] r_cq, n_cq;
    logic [QUERY_W-1:0] r_fq, n_fq;

    logic [AW:0]        r_scan, n_scan;
    logic               r_dv, n_dv;
    logic [AW-1:0]      r_ridx, n_ridx;
    logic               r_have, n_have;
    logic [AW-1:0]      r_pidx, n_pidx;
    logic [VW-1:0]      r_pver, n_pver;
    logic [ENTRY_COUNT-1:0] r_init, n_init;

    logic               r_strobe, n_strobe;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [IDX_W-1:0]   r_oidx, n_oidx;
    logic [HVER_W-1:0]  r_over, n_over;
    logic               r_hv, n_hv;
    logic               r_al, n_al;
    logic               r_im, n_im;
    logic               r_hc, n_hc;
    logic               r_af, n_af;
    logic               r_last, n_last;

    logic               we;
    logic [AW-1:0]      waddr, raddr;
    logic [EW-1:0]      wdata, ram_q, rd;

    logic [VW-1:0]      sv;
    logic               sa, si;
    logic [CC-1:0]      sc, cbit;
    logic [FW-1:0]      sf;
    logic [31:0]        ver32, cq32, fq32;
    logic               inrange, valid, cid_ok, hit, free_ent, exhausted;

    get_ram #(
        .WIDTH(EW),
        .DEPTH(ENTRY_COUNT)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(ram_q)
    );

    always_comb begin
        rd       = r_init[r_ridx] ? ram_q : '0;
        sv       = rd[VW-1:0];
        sa       = rd[AL];
        si       = rd[IL];
        sc       = rd[CL +: CC];
        sf       = rd[FL +: FW];
        ver32    = 32'(r_ver);
        cq32     = 32'(r_cq);
        fq32     = 32'(r_fq);
        inrange  = {1'b0, r_idx} < (IDX_W + 1)'(ENTRY_COUNT);
        valid    = inrange && (sv == ver32[VW-1:0]);
        cid_ok   = 32'(r_cid) < 32'(CC);
        cbit     = cid_ok ? (CC'(1) << r_cid) : '0;
        free_ent = !sa && !si;
        hit      = sa && ((32'(sc) & cq32) == cq32) && ((32'(sf) & fq32) == fq32);
        exhausted = !r_dv && (r_scan == (AW + 1)'(ENTRY_COUNT));
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_idx    = r_idx;
        n_ver    = r_ver;
        n_cid    = r_cid;
        n_imm    = r_imm;
        n_cq     = r_cq;
        n_fq     = r_fq;
        n_scan   = r_scan;
        n_dv     = 1'b0;
        n_ridx   = r_ridx;
        n_have   = r_have;
        n_pidx   = r_pidx;
        n_pver   = r_pver;
        n_init   = r_init;
        n_strobe = 1'b0;
        n_status = ST_OK;
        n_oidx   = '0;
        n_over   = '0;
        n_hv     = 1'b0;
        n_al     = 1'b0;
        n_im     = 1'b0;
        n_hc     = 1'b0;
        n_af     = 1'b0;
        n_last   = 1'b1;
        we       = 1'b0;
        waddr    = r_ridx;
        wdata    = rd;
        raddr    = r_scan[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd  = i_command;
                    n_idx  = i_entry_index;
                    n_ver  = i_entry_version;
                    n_cid  = i_component_id;
                    n_imm  = i_immortal_value;
                    n_cq   = i_component_query;
                    n_fq   = i_flag_bits;
                    n_have = 1'b0;
                    if (i_command == CMD_CREATE || i_command == CMD_FIND
                        || i_command == CMD_ITERATE) begin
                        raddr   = '0;
                        n_ridx  = '0;
                        n_dv    = 1'b1;
                        n_scan  = (AW + 1)'(1);
                        n_state = S_SCAN;
                    end else begin
                        raddr   = i_entry_index[AW-1:0];
                        n_ridx  = i_entry_index[AW-1:0];
                        n_state = S_EXEC;
                    end
                end
            end

            S_EXEC: begin
                n_strobe = 1'b1;
                n_state  = S_IDLE;
                n_oidx   = r_idx;
                n_over   = inrange ? HVER_W'(32'(sv)) : '0;
                if (r_cmd > CMD_ITERATE) begin
                    n_status = ST_REJECTED;
                    n_oidx   = '0;
                    n_over   = '0;
                end else if (r_cmd == CMD_QUERY) begin
                    n_status = valid ? ST_OK : ST_INVALID;
                    n_hv     = valid;
                    n_al     = inrange && sa;
                    n_im     = valid && si;
                    n_hc     = valid && (|(sc & cbit));
                    n_af     = valid && (|(32'(sf) & fq32));
                end else if (!valid) begin
                    n_status = ST_INVALID;
                end else begin
                    case (r_cmd)
                        CMD_KILL: begin
                            wdata[AL] = 1'b0;
                            if (!si) begin
                                wdata[VW-1:0]  = sv + VW'(1);
                                wdata[CL +: CC] = '0;
                            end
                            we = 1'b1;
                        end
                        CMD_REINCARNATE: begin
                            if (sa || !si) begin
                                n_status = ST_REJECTED;
                            end else begin
                                wdata[AL] = 1'b1;
                                we        = 1'b1;
                            end
                        end
                        CMD_SET_IMMORT: begin
                            wdata[IL] = r_imm;
                            we        = 1'b1;
                        end
                        CMD_ADD_COMP: begin
                            if (!cid_ok || (|(sc & cbit))) begin
                                n_status = ST_REJECTED;
                            end else begin
                                wdata[CL +: CC] = sc | cbit;
                                we              = 1'b1;
                            end
                        end
                        CMD_REM_COMP: begin
                            if (!cid_ok || !(|(sc & cbit))) begin
                                n_status = ST_REJECTED;
                            end else begin
                                wdata[CL +: CC] = sc & ~cbit;
                                we              = 1'b1;
                            end
                        end
                        CMD_SET_FLAGS: begin
                            wdata[FL +: FW] = sf | FW'(fq32);
                            we              = 1'b1;
                        end
                        default: begin
                            wdata[FL +: FW] = sf & ~FW'(fq32);
                            we              = 1'b1;
                        end
                    endcase
                    n_over = HVER_W'(32'(wdata[VW-1:0]));
                end
                if (we) begin
                    n_init[r_ridx] = 1'b1;
                end
            end

            S_SCAN: begin
                if (r_scan != (AW + 1)'(ENTRY_COUNT)) begin
                    n_dv   = 1'b1;
                    n_ridx = r_scan[AW-1:0];
                    n_scan = r_scan + (AW + 1)'(1);
                end
                if (r_dv) begin
                    if (r_cmd == CMD_CREATE) begin
                        if (free_ent) begin
                            wdata[VW-1:0]  = sv + VW'(1);
                            wdata[AL]      = 1'b1;
                            we             = 1'b1;
                            n_init[r_ridx] = 1'b1;
                            n_strobe       = 1'b1;
                            n_oidx         = IDX_W'(r_ridx);
                            n_over         = HVER_W'(32'(wdata[VW-1:0]));
                            n_state        = S_IDLE;
                        end
                    end else if (hit) begin
                        if (r_cmd == CMD_FIND) begin
                            n_strobe = 1'b1;
                            n_oidx   = IDX_W'(r_ridx);
                            n_over   = HVER_W'(32'(sv));
                            n_state  = S_IDLE;
                        end else begin
                            if (r_have) begin
                                n_strobe = 1'b1;
                                n_oidx   = IDX_W'(r_pidx);
                                n_over   = HVER_W'(32'(r_pver));
                                n_last   = 1'b0;
                            end
                            n_have = 1'b1;
                            n_pidx = r_ridx;
                            n_pver = sv;
                        end
                    end
                end else if (exhausted) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                    if (r_cmd == CMD_CREATE) begin
                        n_status = ST_FULL;
                    end else if (r_cmd == CMD_ITERATE && r_have) begin
                        n_oidx = IDX_W'(r_pidx);
                        n_over = HVER_W'(32'(r_pver));
                    end else begin
                        n_status = ST_NO_MATCH;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_init   <= '0;
            r_strobe <= 1'b0;
            r_dv     <= 1'b0;
            r_have   <= 1'b0;
            r_scan   <= '0;
        end else begin
            r_state  <= n_state;
            r_init   <= n_init;
            r_strobe <= n_strobe;
            r_dv     <= n_dv;
            r_have   <= n_have;
            r_scan   <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_idx    <= n_idx;
        r_ver    <= n_ver;
        r_cid    <= n_cid;
        r_imm    <= n_imm;
        r_cq     <= n_cq;
        r_fq     <= n_fq;
        r_ridx   <= n_ridx;
        r_pidx   <= n_pidx;
        r_pver   <= n_pver;
        r_status <= n_status;
        r_oidx   <= n_oidx;
        r_over   <= n_over;
        r_hv     <= n_hv;
        r_al     <= n_al;
        r_im     <= n_im;
        r_hc     <= n_hc;
        r_af     <= n_af;
        r_last   <= n_last;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_out_index     = r_oidx;
    assign o_out_version   = r_over;
    assign o_handle_valid  = r_hv;
    assign o_is_alive      = r_al;
    assign o_is_immortal   = r_im;
    assign o_has_component = r_hc;
    assign o_any_flag      = r_af;
    assign o_last          = r_last;

    // The final result of a request is never followed directly by another result.
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> !o_strobe)
        else $error("result directly after a final result");

    // Only iterate produces results that are not final.
    a_multi_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> r_cmd == CMD_ITERATE)
        else $error("non-final result from a single-result command");

    // An accepted request always makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted without going busy");

    // A non-final result means a pending match is held for the next one.
    a_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> r_have)
        else $error("non-final result with no pending match");

endmodule

@@ src/get_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module get_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
